@@ rtl/core/lens_distortion_projection_defines.svh @@
// Assertion macros for the lens distortion projection block
`ifndef LENS_DISTORTION_PROJECTION_DEFINES_SVH
`define LENS_DISTORTION_PROJECTION_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define LDP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle
`define LDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ldp_pkg.sv @@
// Shared types, constants and saturating helpers of the lens projection block
package ldp_pkg;

  // Internal dimensionless values: signed, saturated to [-2^62, 2^62-1]
  localparam int IW = 63;
  typedef logic signed [IW-1:0] int_t;

  localparam int_t IMAX = {1'b0, {(IW-1){1'b1}}};
  localparam int_t IMIN = {1'b1, {(IW-1){1'b0}}};

  localparam int FRAC = 28;
  localparam int KFRAC = 24;
  localparam int_t ONE = int_t'(64'sd1 <<< FRAC);

  // Pipelined multiplier latency in cycles
  localparam int MUL_LAT = 4;

  localparam int FIELD_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int DEF_COORD_WIDTH = 32;
  localparam logic [31:0] IMAGE_SIZE_RST = 32'd41944000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_XY     = 3'd0,
    CFG_CENTER_XY    = 3'd1,
    CFG_RADIAL_K1    = 3'd2,
    CFG_RADIAL_K2    = 3'd3,
    CFG_RADIAL_K3    = 3'd4,
    CFG_TANGENTIAL_P = 3'd5,
    CFG_IMAGE_SIZE   = 3'd6
  } cfg_idx_e;

  // Saturating add to the internal range
  function automatic int_t sadd(int_t a, int_t b);
    logic [IW:0] s;
    s = {a[IW-1], a} + {b[IW-1], b};
    if (s[IW] != s[IW-1]) begin
      return s[IW] ? IMIN : IMAX;
    end
    return int_t'(s[IW-1:0]);
  endfunction

  // Saturating doubling
  function automatic int_t dbl(int_t a);
    return sadd(a, a);
  endfunction

endpackage

@@ rtl/core/ldp_point_if.sv @@
// Input point channel: normalised camera-plane coordinates
interface ldp_point_if;
  logic valid;
  logic ready;
  logic signed [ldp_pkg::FIELD_W-1:0] norm_x;
  logic signed [ldp_pkg::FIELD_W-1:0] norm_y;

  modport source(output valid, norm_x, norm_y, input ready);
  modport sink(input valid, norm_x, norm_y, output ready);
endinterface

@@ rtl/core/ldp_result_if.sv @@
// Result channel: pixel coordinates, outside flag and Jacobian
interface ldp_result_if;
  logic valid;
  logic ready;
  logic signed [ldp_pkg::FIELD_W-1:0] pixel_u;
  logic signed [ldp_pkg::FIELD_W-1:0] pixel_v;
  logic outside_image;
  logic signed [ldp_pkg::FIELD_W-1:0] jac_u_by_x;
  logic signed [ldp_pkg::FIELD_W-1:0] jac_u_by_y;
  logic signed [ldp_pkg::FIELD_W-1:0] jac_v_by_x;
  logic signed [ldp_pkg::FIELD_W-1:0] jac_v_by_y;

  modport source(output valid, pixel_u, pixel_v, outside_image, jac_u_by_x, jac_u_by_y,
                 jac_v_by_x, jac_v_by_y, input ready);
  modport sink(input valid, pixel_u, pixel_v, outside_image, jac_u_by_x, jac_u_by_y,
               jac_v_by_x, jac_v_by_y, output ready);
endinterface

@@ rtl/core/ldp_cfg_if.sv @@
// Configuration write channel: register index and write data
interface ldp_cfg_if;
  logic valid;
  logic ready;
  logic [ldp_pkg::CFG_IDX_W-1:0] index;
  logic [ldp_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/core/ldp_dly.sv @@
// Enabled shift-register delay line for pipeline side data
module ldp_dly #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  // Advance the line on enable
  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

@@ rtl/core/ldp_mul.sv @@
// Four-stage signed multiply, floor shift and saturation to the internal range
module ldp_mul #(
  parameter int SH = ldp_pkg::FRAC
) (
  input  logic          clk,
  input  logic          en,
  input  ldp_pkg::int_t a,
  input  ldp_pkg::int_t b,
  output ldp_pkg::int_t p
);

  localparam int IW = ldp_pkg::IW;
  localparam int LW = 32;
  localparam int HW = IW - LW;
  localparam int PW = 2 * IW;
  localparam int QW = PW - SH;

  logic [IW-1:0]      ua, ub;
  logic               n1, n2, n3;
  logic [2*LW-1:0]    ll;
  logic [LW+HW-1:0]   lh, hl;
  logic [2*HW-1:0]    hh;
  logic [PW-1:0]      mag;
  logic [QW-1:0]      q;
  logic               rem, big;
  logic [IW-1:0]      qlo;

  // Stage 1: take magnitudes and the result sign
  always_ff @(posedge clk) begin
    if (en) begin
      n1 <= a[IW-1] ^ b[IW-1];
      ua <= a[IW-1] ? IW'(-a) : IW'(a);
      ub <= b[IW-1] ? IW'(-b) : IW'(b);
    end
  end

  // Stage 2: four partial products of the 32-bit low and 31-bit high halves
  always_ff @(posedge clk) begin
    if (en) begin
      n2 <= n1;
      ll <= ua[LW-1:0] * ub[LW-1:0];
      lh <= ua[LW-1:0] * ub[IW-1:LW];
      hl <= ua[IW-1:LW] * ub[LW-1:0];
      hh <= ua[IW-1:LW] * ub[IW-1:LW];
    end
  end

  // Stage 3: sum the partial products
  always_ff @(posedge clk) begin
    if (en) begin
      n3  <= n2;
      mag <= (PW'(hh) << (2*LW)) + (PW'(lh) << LW) + (PW'(hl) << LW) + PW'(ll);
    end
  end

  // Stage 4: shift, round toward minus infinity, saturate
  assign q   = mag[PW-1:SH];
  assign rem = |mag[SH-1:0];
  assign big = |q[QW-1:IW-1];
  assign qlo = {1'b0, q[IW-2:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      if (big) begin
        p <= n3 ? ldp_pkg::IMIN : ldp_pkg::IMAX;
      end else if (n3) begin
        p <= -(ldp_pkg::int_t'(qlo) + ldp_pkg::int_t'(IW'(rem)));
      end else begin
        p <= ldp_pkg::int_t'(qlo);
      end
    end
  end

endmodule

@@ rtl/core/lens_distortion_projection.sv @@
// Top level of the lens distortion projection pipeline.
// Takes one normalised point (Q4.28) per cycle unless the output stalls, and
// returns pixel coordinates, an outside-image flag and the 2x2 Jacobian, all
// Q16.16 and saturated. The pipeline is an input register, six chained levels,
// each a four-stage multiplier bank followed by two registered add stages, and
// then the output register. The whole pipeline advances together; a two-deep
// output register pair keeps requests flowing while one result waits.
// Configuration is taken at any time but must only change while the pipeline
// is empty.
`include "lens_distortion_projection_defines.svh"

module lens_distortion_projection #(
  parameter int COORD_WIDTH = ldp_pkg::DEF_COORD_WIDTH
) (
  input logic          clk,
  input logic          rst,
  ldp_cfg_if.sink      cfg,
  ldp_point_if.sink    point,
  ldp_result_if.source result
);

  localparam int FR  = ldp_pkg::FRAC;
  localparam int KF  = ldp_pkg::KFRAC;
  localparam int ML  = ldp_pkg::MUL_LAT;
  localparam int LVL = ML + 2;
  localparam int NSTG = 1 + 6 * LVL;
  localparam int OW = COORD_WIDTH > 32 ? 32 : (COORD_WIDTH < 2 ? 2 : COORD_WIDTH);
  localparam ldp_pkg::int_t OMAX = ldp_pkg::int_t'((64'sd1 <<< (OW-1)) - 64'sd1);
  localparam ldp_pkg::int_t OMIN = ldp_pkg::int_t'(-(64'sd1 <<< (OW-1)));

  typedef ldp_pkg::int_t int_t;

  typedef struct packed { int_t x, y; } l0_t;
  typedef struct packed {
    int_t x, y, r2, dx2, dy2, xy, gk1x, gk1y, sxy, p2x3, p1y3, p1y2, p2x2;
  } l1a_t;
  typedef struct packed {
    int_t x, y, r2, tx2, ty2, xy, gk1x, gk1y, sxy, jup, jvp;
  } l1_t;
  typedef struct packed {
    int_t x, y, r2, r4, xr2, yr2, d1, gk1x, gk1y, sxy, jup, jvp, xdp, ydp, p2t, p1t;
  } l2_t;
  typedef struct packed {
    int_t x, y, r6, xr4, yr4, d2, gx1, gy1, sxy, jup, jvp, xdp, ydp, p2t, p1t;
  } l3_t;
  typedef struct packed {
    int_t x, y, d, gx1, gy1, g3x, g3y, sxy, jup, jvp, xdp, ydp, p2t, p1t;
  } l4a_t;
  typedef struct packed {
    int_t x, y, d, gx, gy, sxy, jup, jvp, xdp, ydp, p2t, p1t;
  } l4_t;
  typedef struct packed {
    int_t xd1, yd1, juu1, juy, jvx, jvy1, jup, jvp, p2t, p1t;
  } l5a_t;
  typedef struct packed { int_t xd, yd, juu, juy, jvx, jvy; } l5_t;
  typedef struct packed { int_t u, v, j0, j1, j2, j3; } l6a_t;
  typedef struct packed {
    logic [31:0] pixel_u, pixel_v;
    logic        outside;
    logic [31:0] jux, juy, jvx, jvy;
  } res_t;

  // Configuration registers
  logic [63:0] focal_xy, center_xy, tangential_p;
  logic [31:0] radial_k1, radial_k2, radial_k3, image_size;

  int_t k1, k2, k3, p1, p2, fx, fy, cx, cy, widq, hgtq;

  logic              adv;
  logic [NSTG-1:0]   vld;
  l0_t  l0, l0d;
  l1a_t a1;
  l1_t  l1, l1d;
  l2_t  a2, l2, l2d;
  l3_t  a3, l3, l3d;
  l4a_t a4;
  l4_t  l4, l4d;
  l5a_t a5;
  l5_t  l5;
  l6a_t a6;
  res_t fin, out_data, skid_data;
  logic out_valid, skid_valid;
  logic fin_neg;

  int_t m1_x2, m1_y2, m1_xy, m1_k1x, m1_k1y, m1_p1x, m1_p1y, m1_p2x, m1_p2y;
  int_t m2_r4, m2_xr2, m2_yr2, m2_k1r2, m2_p1xy, m2_p2xy, m2_p2t, m2_p1t;
  int_t m3_r6, m3_xr4, m3_yr4, m3_k2r4, m3_k2xr2, m3_k2yr2;
  int_t m4_k3r6, m4_k3xr4, m4_k3yr4;
  int_t m5_xd, m5_yd, m5_xgx, m5_ygx, m5_xgy, m5_ygy;
  int_t m6_u, m6_v, m6_j0, m6_j1, m6_j2, m6_j3;

  // Clamp an internal Q.16 value to the output range
  function automatic logic [31:0] sat_o(int_t v);
    int_t c;
    c = v > OMAX ? OMAX : (v < OMIN ? OMIN : v);
    return c[31:0];
  endfunction

  // Take configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_xy     <= '0;
      center_xy    <= '0;
      radial_k1    <= '0;
      radial_k2    <= '0;
      radial_k3    <= '0;
      tangential_p <= '0;
      image_size   <= ldp_pkg::IMAGE_SIZE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ldp_pkg::CFG_FOCAL_XY:     focal_xy     <= cfg.data;
        ldp_pkg::CFG_CENTER_XY:    center_xy    <= cfg.data;
        ldp_pkg::CFG_RADIAL_K1:    radial_k1    <= cfg.data[31:0];
        ldp_pkg::CFG_RADIAL_K2:    radial_k2    <= cfg.data[31:0];
        ldp_pkg::CFG_RADIAL_K3:    radial_k3    <= cfg.data[31:0];
        ldp_pkg::CFG_TANGENTIAL_P: tangential_p <= cfg.data;
        ldp_pkg::CFG_IMAGE_SIZE:   image_size   <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

  // Widen coefficients to the internal format
  assign k1 = int_t'($signed(radial_k1));
  assign k2 = int_t'($signed(radial_k2));
  assign k3 = int_t'($signed(radial_k3));
  assign p1 = int_t'($signed(tangential_p[63:32]));
  assign p2 = int_t'($signed(tangential_p[31:0]));
  assign fx = int_t'({31'b0, focal_xy[63:32]});
  assign fy = int_t'({31'b0, focal_xy[31:0]});
  assign cx = int_t'({31'b0, center_xy[63:32]});
  assign cy = int_t'({31'b0, center_xy[31:0]});
  assign widq = int_t'({31'b0, image_size[31:16], 16'b0});
  assign hgtq = int_t'({31'b0, image_size[15:0], 16'b0});

  // Advance the whole pipeline unless the skid register is occupied
  assign adv = !skid_valid;
  assign point.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], point.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l0.x <= int_t'(point.norm_x);
      l0.y <= int_t'(point.norm_y);
    end
  end

  // Level 1: squares, cross term and first-order coefficient products
  ldp_mul #(.SH(FR)) u_m1_x2  (.clk, .en(adv), .a(l0.x), .b(l0.x), .p(m1_x2));
  ldp_mul #(.SH(FR)) u_m1_y2  (.clk, .en(adv), .a(l0.y), .b(l0.y), .p(m1_y2));
  ldp_mul #(.SH(FR)) u_m1_xy  (.clk, .en(adv), .a(l0.x), .b(l0.y), .p(m1_xy));
  ldp_mul #(.SH(KF)) u_m1_k1x (.clk, .en(adv), .a(k1), .b(l0.x), .p(m1_k1x));
  ldp_mul #(.SH(KF)) u_m1_k1y (.clk, .en(adv), .a(k1), .b(l0.y), .p(m1_k1y));
  ldp_mul #(.SH(KF)) u_m1_p1x (.clk, .en(adv), .a(p1), .b(l0.x), .p(m1_p1x));
  ldp_mul #(.SH(KF)) u_m1_p1y (.clk, .en(adv), .a(p1), .b(l0.y), .p(m1_p1y));
  ldp_mul #(.SH(KF)) u_m1_p2x (.clk, .en(adv), .a(p2), .b(l0.x), .p(m1_p2x));
  ldp_mul #(.SH(KF)) u_m1_p2y (.clk, .en(adv), .a(p2), .b(l0.y), .p(m1_p2y));
  ldp_dly #(.W($bits(l0_t)), .N(ML)) u_d0 (.clk, .en(adv), .d(l0), .q(l0d));

  always_ff @(posedge clk) begin
    if (adv) begin
      a1.x    <= l0d.x;
      a1.y    <= l0d.y;
      a1.r2   <= ldp_pkg::sadd(m1_x2, m1_y2);
      a1.dx2  <= ldp_pkg::dbl(m1_x2);
      a1.dy2  <= ldp_pkg::dbl(m1_y2);
      a1.xy   <= m1_xy;
      a1.gk1x <= ldp_pkg::dbl(m1_k1x);
      a1.gk1y <= ldp_pkg::dbl(m1_k1y);
      a1.sxy  <= ldp_pkg::sadd(ldp_pkg::dbl(m1_p1x), ldp_pkg::dbl(m1_p2y));
      a1.p2x3 <= ldp_pkg::sadd(ldp_pkg::dbl(m1_p2x), ldp_pkg::dbl(ldp_pkg::dbl(m1_p2x)));
      a1.p1y3 <= ldp_pkg::sadd(ldp_pkg::dbl(m1_p1y), ldp_pkg::dbl(ldp_pkg::dbl(m1_p1y)));
      a1.p1y2 <= ldp_pkg::dbl(m1_p1y);
      a1.p2x2 <= ldp_pkg::dbl(m1_p2x);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l1.x    <= a1.x;
      l1.y    <= a1.y;
      l1.r2   <= a1.r2;
      l1.tx2  <= ldp_pkg::sadd(a1.r2, a1.dx2);
      l1.ty2  <= ldp_pkg::sadd(a1.r2, a1.dy2);
      l1.xy   <= a1.xy;
      l1.gk1x <= a1.gk1x;
      l1.gk1y <= a1.gk1y;
      l1.sxy  <= a1.sxy;
      l1.jup  <= ldp_pkg::sadd(a1.p1y2, a1.p2x3);
      l1.jvp  <= ldp_pkg::sadd(a1.p2x2, a1.p1y3);
    end
  end

  // Level 2: fourth power, tangential terms, first radial term
  ldp_mul #(.SH(FR)) u_m2_r4   (.clk, .en(adv), .a(l1.r2), .b(l1.r2), .p(m2_r4));
  ldp_mul #(.SH(FR)) u_m2_xr2  (.clk, .en(adv), .a(l1.x), .b(l1.r2), .p(m2_xr2));
  ldp_mul #(.SH(FR)) u_m2_yr2  (.clk, .en(adv), .a(l1.y), .b(l1.r2), .p(m2_yr2));
  ldp_mul #(.SH(KF)) u_m2_k1r2 (.clk, .en(adv), .a(k1), .b(l1.r2), .p(m2_k1r2));
  ldp_mul #(.SH(KF)) u_m2_p1xy (.clk, .en(adv), .a(p1), .b(l1.xy), .p(m2_p1xy));
  ldp_mul #(.SH(KF)) u_m2_p2xy (.clk, .en(adv), .a(p2), .b(l1.xy), .p(m2_p2xy));
  ldp_mul #(.SH(KF)) u_m2_p2t  (.clk, .en(adv), .a(p2), .b(l1.tx2), .p(m2_p2t));
  ldp_mul #(.SH(KF)) u_m2_p1t  (.clk, .en(adv), .a(p1), .b(l1.ty2), .p(m2_p1t));
  ldp_dly #(.W($bits(l1_t)), .N(ML)) u_d1 (.clk, .en(adv), .d(l1), .q(l1d));

  always_ff @(posedge clk) begin
    if (adv) begin
      a2.x    <= l1d.x;
      a2.y    <= l1d.y;
      a2.r2   <= l1d.r2;
      a2.r4   <= m2_r4;
      a2.xr2  <= m2_xr2;
      a2.yr2  <= m2_yr2;
      a2.d1   <= ldp_pkg::sadd(ldp_pkg::ONE, m2_k1r2);
      a2.gk1x <= l1d.gk1x;
      a2.gk1y <= l1d.gk1y;
      a2.sxy  <= l1d.sxy;
      a2.jup  <= l1d.jup;
      a2.jvp  <= l1d.jvp;
      a2.xdp  <= ldp_pkg::dbl(m2_p1xy);
      a2.ydp  <= ldp_pkg::dbl(m2_p2xy);
      a2.p2t  <= m2_p2t;
      a2.p1t  <= m2_p1t;
      l2      <= a2;
    end
  end

  // Level 3: sixth power and second radial terms
  ldp_mul #(.SH(FR)) u_m3_r6    (.clk, .en(adv), .a(l2.r4), .b(l2.r2), .p(m3_r6));
  ldp_mul #(.SH(FR)) u_m3_xr4   (.clk, .en(adv), .a(l2.x), .b(l2.r4), .p(m3_xr4));
  ldp_mul #(.SH(FR)) u_m3_yr4   (.clk, .en(adv), .a(l2.y), .b(l2.r4), .p(m3_yr4));
  ldp_mul #(.SH(KF)) u_m3_k2r4  (.clk, .en(adv), .a(k2), .b(l2.r4), .p(m3_k2r4));
  ldp_mul #(.SH(KF)) u_m3_k2xr2 (.clk, .en(adv), .a(k2), .b(l2.xr2), .p(m3_k2xr2));
  ldp_mul #(.SH(KF)) u_m3_k2yr2 (.clk, .en(adv), .a(k2), .b(l2.yr2), .p(m3_k2yr2));
  ldp_dly #(.W($bits(l2_t)), .N(ML)) u_d2 (.clk, .en(adv), .d(l2), .q(l2d));

  always_ff @(posedge clk) begin
    if (adv) begin
      a3.x   <= l2d.x;
      a3.y   <= l2d.y;
      a3.r6  <= m3_r6;
      a3.xr4 <= m3_xr4;
      a3.yr4 <= m3_yr4;
      a3.d2  <= ldp_pkg::sadd(l2d.d1, m3_k2r4);
      a3.gx1 <= ldp_pkg::sadd(l2d.gk1x, ldp_pkg::dbl(ldp_pkg::dbl(m3_k2xr2)));
      a3.gy1 <= ldp_pkg::sadd(l2d.gk1y, ldp_pkg::dbl(ldp_pkg::dbl(m3_k2yr2)));
      a3.sxy <= l2d.sxy;
      a3.jup <= l2d.jup;
      a3.jvp <= l2d.jvp;
      a3.xdp <= l2d.xdp;
      a3.ydp <= l2d.ydp;
      a3.p2t <= l2d.p2t;
      a3.p1t <= l2d.p1t;
      l3     <= a3;
    end
  end

  // Level 4: third radial terms, finish the radial factor and its slopes
  ldp_mul #(.SH(KF)) u_m4_k3r6  (.clk, .en(adv), .a(k3), .b(l3.r6), .p(m4_k3r6));
  ldp_mul #(.SH(KF)) u_m4_k3xr4 (.clk, .en(adv), .a(k3), .b(l3.xr4), .p(m4_k3xr4));
  ldp_mul #(.SH(KF)) u_m4_k3yr4 (.clk, .en(adv), .a(k3), .b(l3.yr4), .p(m4_k3yr4));
  ldp_dly #(.W($bits(l3_t)), .N(ML)) u_d3 (.clk, .en(adv), .d(l3), .q(l3d));

  always_ff @(posedge clk) begin
    if (adv) begin
      a4.x   <= l3d.x;
      a4.y   <= l3d.y;
      a4.d   <= ldp_pkg::sadd(l3d.d2, m4_k3r6);
      a4.gx1 <= l3d.gx1;
      a4.gy1 <= l3d.gy1;
      a4.g3x <= ldp_pkg::sadd(ldp_pkg::dbl(ldp_pkg::dbl(m4_k3xr4)), ldp_pkg::dbl(m4_k3xr4));
      a4.g3y <= ldp_pkg::sadd(ldp_pkg::dbl(ldp_pkg::dbl(m4_k3yr4)), ldp_pkg::dbl(m4_k3yr4));
      a4.sxy <= l3d.sxy;
      a4.jup <= l3d.jup;
      a4.jvp <= l3d.jvp;
      a4.xdp <= l3d.xdp;
      a4.ydp <= l3d.ydp;
      a4.p2t <= l3d.p2t;
      a4.p1t <= l3d.p1t;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l4.x   <= a4.x;
      l4.y   <= a4.y;
      l4.d   <= a4.d;
      l4.gx  <= ldp_pkg::sadd(a4.gx1, a4.g3x);
      l4.gy  <= ldp_pkg::sadd(a4.gy1, a4.g3y);
      l4.sxy <= a4.sxy;
      l4.jup <= a4.jup;
      l4.jvp <= a4.jvp;
      l4.xdp <= a4.xdp;
      l4.ydp <= a4.ydp;
      l4.p2t <= a4.p2t;
      l4.p1t <= a4.p1t;
    end
  end

  // Level 5: distorted point and Jacobian factors
  ldp_mul #(.SH(FR)) u_m5_xd  (.clk, .en(adv), .a(l4.x), .b(l4.d), .p(m5_xd));
  ldp_mul #(.SH(FR)) u_m5_yd  (.clk, .en(adv), .a(l4.y), .b(l4.d), .p(m5_yd));
  ldp_mul #(.SH(FR)) u_m5_xgx (.clk, .en(adv), .a(l4.x), .b(l4.gx), .p(m5_xgx));
  ldp_mul #(.SH(FR)) u_m5_ygx (.clk, .en(adv), .a(l4.y), .b(l4.gx), .p(m5_ygx));
  ldp_mul #(.SH(FR)) u_m5_xgy (.clk, .en(adv), .a(l4.x), .b(l4.gy), .p(m5_xgy));
  ldp_mul #(.SH(FR)) u_m5_ygy (.clk, .en(adv), .a(l4.y), .b(l4.gy), .p(m5_ygy));
  ldp_dly #(.W($bits(l4_t)), .N(ML)) u_d4 (.clk, .en(adv), .d(l4), .q(l4d));

  always_ff @(posedge clk) begin
    if (adv) begin
      a5.xd1  <= ldp_pkg::sadd(m5_xd, l4d.xdp);
      a5.yd1  <= ldp_pkg::sadd(m5_yd, l4d.ydp);
      a5.juu1 <= ldp_pkg::sadd(l4d.d, m5_xgx);
      a5.juy  <= ldp_pkg::sadd(m5_xgy, l4d.sxy);
      a5.jvx  <= ldp_pkg::sadd(m5_ygx, l4d.sxy);
      a5.jvy1 <= ldp_pkg::sadd(l4d.d, m5_ygy);
      a5.jup  <= l4d.jup;
      a5.jvp  <= l4d.jvp;
      a5.p2t  <= l4d.p2t;
      a5.p1t  <= l4d.p1t;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l5.xd  <= ldp_pkg::sadd(a5.xd1, a5.p2t);
      l5.yd  <= ldp_pkg::sadd(a5.yd1, a5.p1t);
      l5.juu <= ldp_pkg::sadd(a5.juu1, a5.jup);
      l5.juy <= a5.juy;
      l5.jvx <= a5.jvx;
      l5.jvy <= ldp_pkg::sadd(a5.jvy1, a5.jvp);
    end
  end

  // Level 6: apply focal lengths and principal point
  ldp_mul #(.SH(FR)) u_m6_u  (.clk, .en(adv), .a(fx), .b(l5.xd), .p(m6_u));
  ldp_mul #(.SH(FR)) u_m6_v  (.clk, .en(adv), .a(fy), .b(l5.yd), .p(m6_v));
  ldp_mul #(.SH(FR)) u_m6_j0 (.clk, .en(adv), .a(fx), .b(l5.juu), .p(m6_j0));
  ldp_mul #(.SH(FR)) u_m6_j1 (.clk, .en(adv), .a(fx), .b(l5.juy), .p(m6_j1));
  ldp_mul #(.SH(FR)) u_m6_j2 (.clk, .en(adv), .a(fy), .b(l5.jvx), .p(m6_j2));
  ldp_mul #(.SH(FR)) u_m6_j3 (.clk, .en(adv), .a(fy), .b(l5.jvy), .p(m6_j3));

  always_ff @(posedge clk) begin
    if (adv) begin
      a6.u  <= ldp_pkg::sadd(m6_u, cx);
      a6.v  <= ldp_pkg::sadd(m6_v, cy);
      a6.j0 <= m6_j0;
      a6.j1 <= m6_j1;
      a6.j2 <= m6_j2;
      a6.j3 <= m6_j3;
    end
  end

  // Bounds test on the unclamped values, then clamp to the output range
  always_ff @(posedge clk) begin
    if (adv) begin
      fin.pixel_u <= sat_o(a6.u);
      fin.pixel_v <= sat_o(a6.v);
      fin.outside <= a6.u[ldp_pkg::IW-1] || (a6.u >= widq) ||
                     a6.v[ldp_pkg::IW-1] || (a6.v >= hgtq);
      fin.jux     <= sat_o(a6.j0);
      fin.juy     <= sat_o(a6.j1);
      fin.jvx     <= sat_o(a6.j2);
      fin.jvy     <= sat_o(a6.j3);
    end
  end

  // Output register and skid register: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (vld[NSTG-1]) begin
      if (out_valid && !result.ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register and skid register: payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result.ready) begin
        out_data <= skid_data;
      end
    end else if (vld[NSTG-1]) begin
      if (out_valid && !result.ready) begin
        skid_data <= fin;
      end else begin
        out_data <= fin;
      end
    end
  end

  assign result.valid         = out_valid;
  assign result.pixel_u       = out_data.pixel_u;
  assign result.pixel_v       = out_data.pixel_v;
  assign result.outside_image = out_data.outside;
  assign result.jac_u_by_x    = out_data.jux;
  assign result.jac_u_by_y    = out_data.juy;
  assign result.jac_v_by_x    = out_data.jvx;
  assign result.jac_v_by_y    = out_data.jvy;

  // Checks on the output buffering and the bounds flag
  assign fin_neg = fin.pixel_u[31] || fin.pixel_v[31];

  `LDP_ASSERT_NOW(a_skid_has_out, skid_valid, out_valid, "skid full with output empty")
  `LDP_ASSERT_NEXT(a_stall_holds_last, vld[NSTG-1] && !adv, vld[NSTG-1], "stalled result lost")
  `LDP_ASSERT_NOW(a_inside_nonneg, vld[NSTG-1] && !fin.outside, !fin_neg, "inside point negative")

endmodule

@@ sim/tb.sv @@
// Testbench of the lens distortion projection block: predictor, scoreboard and stimulus
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
  logic signed [31:0] pix_u;
  logic signed [31:0] pix_v;
  logic               outside;
  logic signed [31:0] dudx;
  logic signed [31:0] dudy;
  logic signed [31:0] dvdx;
  logic signed [31:0] dvdy;
} pixel_result_t;

// Scoreboard: own copy of the registers, projection predictor, pending results
class proj_scoreboard;
  bit [63:0] focal;
  bit [63:0] center;
  bit [31:0] k1_reg;
  bit [31:0] k2_reg;
  bit [31:0] k3_reg;
  bit [63:0] tang;
  bit [31:0] img;
  pixel_result_t expected_pix[$];
  int failures;

  function new();
    focal = '0;
    center = '0;
    k1_reg = '0;
    k2_reg = '0;
    k3_reg = '0;
    tang = '0;
    img = ldp_pkg::IMAGE_SIZE_RST;
    failures = 0;
  endfunction

  function void write_reg(ldp_pkg::cfg_idx_e idx, bit [63:0] data);
    case (idx)
      ldp_pkg::CFG_FOCAL_XY:     focal = data;
      ldp_pkg::CFG_CENTER_XY:    center = data;
      ldp_pkg::CFG_RADIAL_K1:    k1_reg = data[31:0];
      ldp_pkg::CFG_RADIAL_K2:    k2_reg = data[31:0];
      ldp_pkg::CFG_RADIAL_K3:    k3_reg = data[31:0];
      ldp_pkg::CFG_TANGENTIAL_P: tang = data;
      ldp_pkg::CFG_IMAGE_SIZE:   img = data[31:0];
      default: ;
    endcase
  endfunction

  // Clamp to the internal range [-2^62, 2^62-1]
  function longint lim(logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = 128'sh3FFF_FFFF_FFFF_FFFF;
    lo = -hi - 1;
    if (v > hi) return longint'(hi);
    if (v < lo) return longint'(lo);
    return longint'(v);
  endfunction

  // Exact product, floored by the shift, then clamped
  function longint mulq(longint a, longint b, int sh);
    logic signed [127:0] pa;
    logic signed [127:0] pb;
    pa = a;
    pb = b;
    return lim((pa * pb) >>> sh);
  endfunction

  function longint add(longint a, longint b);
    logic signed [127:0] sa;
    logic signed [127:0] sb;
    sa = a;
    sb = b;
    return lim(sa + sb);
  endfunction

  function longint dup(longint a);
    return add(a, a);
  endfunction

  // Output clamp to a 32-bit signed field
  function logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function pixel_result_t project(logic signed [31:0] nx, logic signed [31:0] ny);
    pixel_result_t r;
    longint x, y, fx, fy, cx, cy, k1, k2, k3, p1, p2, wid, hgt;
    longint x2, y2, xy, r2, r4, r6, d, xd, yd, u, v, gx, gy, t;
    longint p1x, p1y, p2x, p2y, juu, juy, jvx, jvy;
    int fr;
    int kf;
    fr = ldp_pkg::FRAC;
    kf = ldp_pkg::KFRAC;
    x = nx;
    y = ny;
    fx = {32'b0, focal[63:32]};
    fy = {32'b0, focal[31:0]};
    cx = {32'b0, center[63:32]};
    cy = {32'b0, center[31:0]};
    k1 = $signed(k1_reg);
    k2 = $signed(k2_reg);
    k3 = $signed(k3_reg);
    p1 = $signed(tang[63:32]);
    p2 = $signed(tang[31:0]);
    wid = {32'b0, img[31:16], 16'b0};
    hgt = {32'b0, img[15:0], 16'b0};

    // Radial factor
    x2 = mulq(x, x, fr);
    y2 = mulq(y, y, fr);
    xy = mulq(x, y, fr);
    r2 = add(x2, y2);
    r4 = mulq(r2, r2, fr);
    r6 = mulq(r4, r2, fr);
    d = add(64'sd1 <<< fr, mulq(k1, r2, kf));
    d = add(d, mulq(k2, r4, kf));
    d = add(d, mulq(k3, r6, kf));

    // Distorted point and pixel mapping
    xd = add(mulq(x, d, fr), dup(mulq(p1, xy, kf)));
    xd = add(xd, mulq(p2, add(r2, dup(x2)), kf));
    yd = add(mulq(y, d, fr), dup(mulq(p2, xy, kf)));
    yd = add(yd, mulq(p1, add(r2, dup(y2)), kf));
    u = add(mulq(fx, xd, fr), cx);
    v = add(mulq(fy, yd, fr), cy);

    // Derivatives of the radial factor
    t = dup(mulq(k2, mulq(x, r2, fr), kf));
    gx = add(dup(mulq(k1, x, kf)), dup(t));
    t = dup(mulq(k3, mulq(x, r4, fr), kf));
    gx = add(gx, add(dup(t), t));
    t = dup(mulq(k2, mulq(y, r2, fr), kf));
    gy = add(dup(mulq(k1, y, kf)), dup(t));
    t = dup(mulq(k3, mulq(y, r4, fr), kf));
    gy = add(gy, add(dup(t), t));

    p1x = dup(mulq(p1, x, kf));
    p1y = dup(mulq(p1, y, kf));
    p2x = dup(mulq(p2, x, kf));
    p2y = dup(mulq(p2, y, kf));

    juu = add(add(d, mulq(x, gx, fr)), add(p1y, add(p2x, dup(p2x))));
    juy = add(mulq(x, gy, fr), add(p1x, p2y));
    jvx = add(mulq(y, gx, fr), add(p1x, p2y));
    jvy = add(add(d, mulq(y, gy, fr)), add(p2x, add(p1y, dup(p1y))));

    r.pix_u = clip32(u);
    r.pix_v = clip32(v);
    r.outside = (u < 0 || u >= wid || v < 0 || v >= hgt);
    r.dudx = clip32(mulq(fx, juu, fr));
    r.dudy = clip32(mulq(fx, juy, fr));
    r.dvdx = clip32(mulq(fy, jvx, fr));
    r.dvdy = clip32(mulq(fy, jvy, fr));
    return r;
  endfunction

  function void note_point(logic signed [31:0] nx, logic signed [31:0] ny);
    expected_pix.push_back(project(nx, ny));
  endfunction

  function void cmp_field(string name, longint e, longint a);
    if (e != a) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, e, a);
    end
  endfunction

  function void check_result(pixel_result_t got);
    pixel_result_t e;
    if (expected_pix.size() == 0) begin
      failures++;
      $display("%0t: unexpected result, u %0d v %0d", $realtime, got.pix_u, got.pix_v);
      return;
    end
    e = expected_pix.pop_front();
    cmp_field("pixel_u", e.pix_u, got.pix_u);
    cmp_field("pixel_v", e.pix_v, got.pix_v);
    cmp_field("outside_image", e.outside, got.outside);
    cmp_field("jac_u_by_x", e.dudx, got.dudx);
    cmp_field("jac_u_by_y", e.dudy, got.dudy);
    cmp_field("jac_v_by_x", e.dvdx, got.dvdx);
    cmp_field("jac_v_by_y", e.dvdy, got.dvdy);
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PIPE_LAT = 38;

  logic clk;
  logic rst;
  bit quiet;
  int stall_left;
  int cycles;
  proj_scoreboard sb;

  ldp_cfg_if cfg_ch();
  ldp_point_if pt_ch();
  ldp_result_if res_ch();

  lens_distortion_projection DUT (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .point(pt_ch),
    .result(res_ch)
  );

  always #10 clk = ~clk;

  // Mostly short gaps, a few long ones; none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Coordinate: mostly within the useful field of view, some large, some raw
  function automatic logic signed [31:0] pick_coord();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(0, 805306368) - 402653184;
    if (r < 15) return $urandom_range(0, 1073741824) - 536870912;
    if (r == 15) return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $urandom;
  endfunction

  // Stall the result side
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      res_ch.ready = 1'b0;
    end else begin
      res_ch.ready = 1'b1;
      stall_left = pick_gap();
    end
  end

  // Monitor handshakes at the rising edge
  always @(posedge clk) begin
    pixel_result_t got;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready)
        sb.write_reg(ldp_pkg::cfg_idx_e'(cfg_ch.index), cfg_ch.data);
      if (pt_ch.valid && pt_ch.ready)
        sb.note_point(pt_ch.norm_x, pt_ch.norm_y);
      if (res_ch.valid && res_ch.ready) begin
        got.pix_u = res_ch.pixel_u;
        got.pix_v = res_ch.pixel_v;
        got.outside = res_ch.outside_image;
        got.dudx = res_ch.jac_u_by_x;
        got.dudy = res_ch.jac_u_by_y;
        got.dvdx = res_ch.jac_v_by_x;
        got.dvdy = res_ch.jac_v_by_y;
        sb.check_result(got);
      end
    end
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL lens_distortion_projection");
      $finish;
    end
  end

  task automatic send_point(logic signed [31:0] nx, logic signed [31:0] ny);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      pt_ch.valid = 1'b0;
    end
    @(negedge clk);
    pt_ch.valid = 1'b1;
    pt_ch.norm_x = nx;
    pt_ch.norm_y = ny;
    @(posedge clk);
    while (!pt_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(ldp_pkg::cfg_idx_e idx, logic [63:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic program_all(logic [63:0] f, logic [63:0] c, logic [31:0] a,
                             logic [31:0] b, logic [31:0] k, logic [63:0] p,
                             logic [31:0] isz);
    write_reg(ldp_pkg::CFG_FOCAL_XY, f);
    write_reg(ldp_pkg::CFG_CENTER_XY, c);
    write_reg(ldp_pkg::CFG_RADIAL_K1, {32'b0, a});
    write_reg(ldp_pkg::CFG_RADIAL_K2, {32'b0, b});
    write_reg(ldp_pkg::CFG_RADIAL_K3, {32'b0, k});
    write_reg(ldp_pkg::CFG_TANGENTIAL_P, p);
    write_reg(ldp_pkg::CFG_IMAGE_SIZE, {32'b0, isz});
  endtask

  // Release the point channel and wait until the pipeline is empty
  task automatic drain();
    @(negedge clk);
    pt_ch.valid = 1'b0;
    while (sb.expected_pix.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  task automatic send_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 199) == 0) quiet = ~quiet;
      send_point(pick_coord(), pick_coord());
    end
    quiet = 1'b0;
  endtask

  // Moderate random lens: coefficients within a few units, focal up to 4096 px
  task automatic random_lens();
    program_all({$urandom_range(0, 32'h1000_0000), $urandom_range(0, 32'h1000_0000)},
                {$urandom_range(0, 32'h0800_0000), $urandom_range(0, 32'h0800_0000)},
                $urandom_range(0, 32'h0400_0000) - 32'h0200_0000,
                $urandom_range(0, 32'h0200_0000) - 32'h0100_0000,
                $urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
                {$urandom_range(0, 32'h0020_0000) - 32'h0010_0000,
                 $urandom_range(0, 32'h0020_0000) - 32'h0010_0000},
                {16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096))});
  endtask

  initial begin
    logic signed [31:0] dir_x[20];
    logic signed [31:0] dir_y[20];
    clk = 1'b0;
    rst = 1'b1;
    quiet = 1'b0;
    stall_left = 0;
    cycles = 0;
    sb = new();
    cfg_ch.valid = 1'b0;
    cfg_ch.index = ldp_pkg::CFG_FOCAL_XY;
    cfg_ch.data = '0;
    pt_ch.valid = 1'b0;
    pt_ch.norm_x = '0;
    pt_ch.norm_y = '0;
    res_ch.ready = 1'b0;
    dir_x = '{32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh1000_0000, 32'sd0, -32'sh1000_0000, 32'sh1000_0000, 32'sh0800_0000,
              -32'sh0800_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sh1000_0000, 32'sd1,
              -32'sd1, 32'sh0400_0000, 32'sh2000_0000, -32'sh2000_0000, 32'sh0123_4567};
    dir_y = '{32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sd0, 32'sh1000_0000, -32'sh1000_0000, 32'sh1000_0000, -32'sh0400_0000,
              32'sh04CC_CCCC, 32'sd0, 32'sh8000_0000, 32'sd0, -32'sd1,
              32'sd1, -32'sh0300_0000, -32'sh2000_0000, 32'sh2000_0000, -32'sh0765_4321};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset configuration
    send_random(15);
    drain();

    // Typical lens, 640x480, with the directed corner points
    program_all({32'd500 << 16, 32'd480 << 16}, {32'd320 << 16, 32'd240 << 16},
                -32'sd4697620, 32'sd1174405, -32'sd167772, {32'sd16777, -32'sd8389},
                {16'd640, 16'd480});
    foreach (dir_x[i]) send_point(dir_x[i], dir_y[i]);
    send_random(260);
    drain();

    repeat (3) begin
      random_lens();
      send_random(260);
      drain();
    end

    // Largest registers throughout, but the second tangential coefficient most negative
    program_all('1, '1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                {32'h7FFF_FFFF, 32'h8000_0000}, 32'hFFFF_FFFF);
    send_random(150);
    drain();

    // Most negative coefficients but the second tangential one, zero image size
    program_all({32'd1, 32'd1}, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                {32'h8000_0000, 32'h7FFF_FFFF}, 32'h0);
    send_random(150);
    drain();

    // Raw random registers
    program_all({$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom,
                $urandom, {$urandom, $urandom}, $urandom);
    send_random(150);
    drain();

    if (sb.failures == 0) begin
      $display("PASS lens_distortion_projection");
    end else begin
      $display("FAIL lens_distortion_projection");
    end
    $finish;
  end
endmodule

`default_nettype wire

@@ lens_distortion_projection.f @@
+incdir+rtl/core
rtl/core/ldp_pkg.sv
rtl/core/ldp_point_if.sv
rtl/core/ldp_result_if.sv
rtl/core/ldp_cfg_if.sv
rtl/core/ldp_dly.sv
rtl/core/ldp_mul.sv
rtl/core/lens_distortion_projection.sv
sim/tb.sv
